// ===== rtl/u8ks_pkg.sv =====
// Shared types and constants for the UTF-8 to keysym decoder.
package u8ks_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CP_W    = 31;
    localparam int unsigned COUNT_W = 3;

    // Code points in this range map to keysyms by adding the offset.
    localparam logic [CP_W-1:0] KS_LOW    = 31'h0000100;
    localparam logic [CP_W-1:0] KS_HIGH   = 31'h010FFFF;
    localparam logic [CP_W-1:0] KS_OFFSET = 31'h1000000;

    typedef struct packed {
        logic [CP_W-1:0]    keysym;
        logic [CP_W-1:0]    code_point;
        logic [COUNT_W-1:0] byte_count;
        logic               invalid;
    } t_result;

endpackage

// ===== rtl/u8ks_if.sv =====
// Stream interfaces for the decoder: raw byte beats in, decoded character beats out.
interface u8ks_in_if;
    logic                          valid;
    logic                          ready;
    logic [u8ks_pkg::BYTE_W-1:0]   data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface u8ks_out_if;
    logic                          valid;
    logic                          ready;
    logic [u8ks_pkg::CP_W-1:0]     keysym;
    logic [u8ks_pkg::CP_W-1:0]     code_point;
    logic [u8ks_pkg::COUNT_W-1:0]  byte_count;
    logic                          invalid;

    modport source (output valid, output keysym, output code_point, output byte_count,
                    output invalid, input ready);
    modport sink   (input valid, input keysym, input code_point, input byte_count,
                    input invalid, output ready);
endinterface

// ===== rtl/u8ks_in_reg.sv =====
// Input register: captures one byte beat and holds it until the decode step takes it.
module u8ks_in_reg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [u8ks_pkg::BYTE_W-1:0] i_byte,
    input  logic                        i_take,
    output logic                        o_ready,
    output logic                        o_valid,
    output logic [u8ks_pkg::BYTE_W-1:0] o_byte
);

    logic                        r_valid;
    logic                        n_valid;
    logic [u8ks_pkg::BYTE_W-1:0] r_byte;

    assign o_ready = !r_valid || i_take;
    assign n_valid = (o_ready && i_valid) ? 1'b1 : (i_take ? 1'b0 : r_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// ===== rtl/u8ks_step.sv =====
// Decode step: character state registers and the per-byte decode and keysym mapping.
module u8ks_step (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  logic [u8ks_pkg::BYTE_W-1:0] i_byte,
    output logic                        o_res_valid,
    output u8ks_pkg::t_result           o_res
);

    localparam logic [u8ks_pkg::COUNT_W-1:0] LEN_1 = 3'd1;
    localparam logic [u8ks_pkg::COUNT_W-1:0] LEN_2 = 3'd2;
    localparam logic [u8ks_pkg::COUNT_W-1:0] LEN_3 = 3'd3;
    localparam logic [u8ks_pkg::COUNT_W-1:0] LEN_4 = 3'd4;
    localparam logic [u8ks_pkg::COUNT_W-1:0] LEN_5 = 3'd5;
    localparam logic [u8ks_pkg::COUNT_W-1:0] LEN_6 = 3'd6;

    logic [u8ks_pkg::CP_W-1:0]    r_acc, n_acc;
    logic [u8ks_pkg::COUNT_W-1:0] r_rem, n_rem;
    logic [u8ks_pkg::COUNT_W-1:0] r_len, n_len;

    logic [u8ks_pkg::CP_W-1:0]    cp;
    logic [u8ks_pkg::COUNT_W-1:0] cnt;
    logic                         bad;
    logic                         res_v;
    logic                         in_range;

    always_comb begin
        n_acc = r_acc;
        n_rem = r_rem;
        n_len = r_len;
        res_v = 1'b0;
        cp    = '0;
        cnt   = LEN_1;
        bad   = 1'b0;
        if (r_rem != '0) begin
            // following byte: shift in its low six bits, top bits unchecked
            n_acc = {r_acc[u8ks_pkg::CP_W-7:0], i_byte[5:0]};
            n_rem = r_rem - 3'd1;
            if (r_rem == 3'd1) begin
                res_v = 1'b1;
                cp    = n_acc;
                cnt   = r_len;
            end
        end else if (i_byte == 8'h00) begin
            // end of string: nothing to report
            res_v = 1'b0;
        end else if (!i_byte[7]) begin
            res_v = 1'b1;
            cp    = {23'd0, i_byte};
        end else if (i_byte[7:5] == 3'b110) begin
            n_acc = {26'd0, i_byte[4:0]};
            n_len = LEN_2;
            n_rem = LEN_2 - 3'd1;
        end else if (i_byte[7:4] == 4'b1110) begin
            n_acc = {27'd0, i_byte[3:0]};
            n_len = LEN_3;
            n_rem = LEN_3 - 3'd1;
        end else if (i_byte[7:3] == 5'b11110) begin
            n_acc = {28'd0, i_byte[2:0]};
            n_len = LEN_4;
            n_rem = LEN_4 - 3'd1;
        end else if (i_byte[7:2] == 6'b111110) begin
            n_acc = {29'd0, i_byte[1:0]};
            n_len = LEN_5;
            n_rem = LEN_5 - 3'd1;
        end else if (i_byte[7:1] == 7'b1111110) begin
            n_acc = {30'd0, i_byte[0]};
            n_len = LEN_6;
            n_rem = LEN_6 - 3'd1;
        end else begin
            // stray following byte or 0xFE/0xFF: flag and skip it
            res_v = 1'b1;
            bad   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_rem <= '0;
            r_len <= '0;
        end else if (i_fire) begin
            r_acc <= n_acc;
            r_rem <= n_rem;
            r_len <= n_len;
        end
    end

    assign in_range = !bad && (cp >= u8ks_pkg::KS_LOW) && (cp <= u8ks_pkg::KS_HIGH);

    always_comb begin
        o_res.code_point = cp;
        o_res.byte_count = cnt;
        o_res.invalid    = bad;
        o_res.keysym     = in_range ? (cp + u8ks_pkg::KS_OFFSET) : cp;
    end

    assign o_res_valid = i_fire && res_v;

endmodule

// ===== rtl/u8ks_out_reg.sv =====
// Output register: holds a decoded character beat until the downstream side takes it.
module u8ks_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  u8ks_pkg::t_result i_res,
    input  logic              i_ready,
    output logic              o_free,
    output logic              o_valid,
    output u8ks_pkg::t_result o_res
);

    logic              r_valid;
    logic              n_valid;
    u8ks_pkg::t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign n_valid = i_load ? 1'b1 : (i_ready ? 1'b0 : r_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== rtl/utf8_to_keysym_decoder.sv =====
// Top level of the legacy UTF-8 (1 to 6 byte) to keysym decoder.
//
//  channel  dir  handshake      payload
//  -------  ---  -------------  ------------------------------------------------
//  i_in     in   valid / ready  data_byte[7:0]
//  o_out    out  valid / ready  keysym[30:0], code_point[30:0], byte_count[2:0],
//                               invalid
//
// One byte beat is accepted per cycle while no held result stalls o_out; a
// character's last byte waits in the input register, then passes through the
// decode step into the result register, which presents it on o_out. The step sets
// the rate: it updates the accumulator and character length once per byte.
// Reset (i_rst_n low, synchronous) clears both valid flags and the state.
// A stall on o_out with a result held blocks the decode step for every byte;
// the input register fills if it is empty, then i_in.ready stays low until the
// result moves on.
module utf8_to_keysym_decoder (
    input  logic            i_clk,
    input  logic            i_rst_n,
    u8ks_in_if.sink         i_in,
    u8ks_out_if.source      o_out
);

    logic                        in_valid_q;
    logic [u8ks_pkg::BYTE_W-1:0] in_byte_q;
    logic                        out_free;
    logic                        take;
    logic                        res_valid;
    u8ks_pkg::t_result           res;
    u8ks_pkg::t_result           out_res;

    // Advance a held byte into the decode step only when the result
    // register can take whatever it produces.
    assign take = in_valid_q && out_free;

    u8ks_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_byte  (i_in.data_byte),
        .i_take  (take),
        .o_ready (i_in.ready),
        .o_valid (in_valid_q),
        .o_byte  (in_byte_q)
    );

    // Decode the byte and update the character state.
    u8ks_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (take),
        .i_byte      (in_byte_q),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Hold the finished character for the downstream side.
    u8ks_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .i_ready (o_out.ready),
        .o_free  (out_free),
        .o_valid (o_out.valid),
        .o_res   (out_res)
    );

    assign o_out.keysym     = out_res.keysym;
    assign o_out.code_point = out_res.code_point;
    assign o_out.byte_count = out_res.byte_count;
    assign o_out.invalid    = out_res.invalid;

endmodule

// ===== rtl/u8ks_checker.sv =====
// Port-level checks for the decoder and the bind that attaches them.
module u8ks_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [u8ks_pkg::CP_W-1:0]    i_keysym,
    input logic [u8ks_pkg::CP_W-1:0]    i_code_point,
    input logic [u8ks_pkg::COUNT_W-1:0] i_byte_count,
    input logic                         i_invalid
);

    // Result valid is low right after a reset edge.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // Stalled result holds.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_keysym)
            && $stable(i_code_point) && $stable(i_byte_count) && $stable(i_invalid))
        else $error("stalled result changed");

    // Flagged lead byte reports zero values and one byte.
    a_invalid_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_invalid |-> i_keysym == '0 && i_code_point == '0
            && i_byte_count == 3'd1)
        else $error("invalid result fields wrong");

    // Keysym mapping matches the code point.
    a_keysym_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_invalid |->
            ((i_code_point >= u8ks_pkg::KS_LOW && i_code_point <= u8ks_pkg::KS_HIGH)
                ? (i_keysym == i_code_point + u8ks_pkg::KS_OFFSET)
                : (i_keysym == i_code_point)))
        else $error("keysym mapping wrong");

    // Single byte characters are ASCII, multi byte counts stay within six.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_invalid |-> i_byte_count != 3'd0 && i_byte_count <= 3'd6
            && (i_byte_count != 3'd1 || i_code_point < 31'd128))
        else $error("byte count inconsistent");

endmodule

bind utf8_to_keysym_decoder u8ks_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_keysym     (o_out.keysym),
    .i_code_point (o_out.code_point),
    .i_byte_count (o_out.byte_count),
    .i_invalid    (o_out.invalid)
);

// ===== bench/utf8_to_keysym_decoder_tb.sv =====
// Self-checking bench for the legacy UTF-8 to keysym decoder: byte beats in, char beats checked.
`timescale 1ns / 1ps

module utf8_to_keysym_decoder_tb;

    // Holds a bit-accurate decoder of its own and the queue of decoded
    // characters still owed by the block.
    class char_scoreboard;
        u8ks_pkg::t_result                  expected_chars[$];
        logic [u8ks_pkg::CP_W-1:0]          acc;
        logic [u8ks_pkg::COUNT_W-1:0]       bytes_left;
        logic [u8ks_pkg::COUNT_W-1:0]       char_len;
        int                                 errors;

        function new();
            acc        = '0;
            bytes_left = '0;
            char_len   = '0;
            errors     = 0;
        endfunction

        function void push_char(logic [u8ks_pkg::CP_W-1:0] cp,
                                logic [u8ks_pkg::COUNT_W-1:0] count, logic bad);
            u8ks_pkg::t_result r;
            r.code_point = cp;
            r.byte_count = count;
            r.invalid    = bad;
            if (!bad && cp >= u8ks_pkg::KS_LOW && cp <= u8ks_pkg::KS_HIGH) begin
                r.keysym = cp + u8ks_pkg::KS_OFFSET;
            end else begin
                r.keysym = cp;
            end
            expected_chars.push_back(r);
        endfunction

        // Advance the decoder by one accepted byte beat.
        function void note_byte(logic [u8ks_pkg::BYTE_W-1:0] b);
            if (bytes_left != 0) begin
                // Following byte: top two bits are never checked.
                acc        = {acc[u8ks_pkg::CP_W-7:0], b[5:0]};
                bytes_left = bytes_left - 1'b1;
                if (bytes_left == 0) begin
                    push_char(acc, char_len, 1'b0);
                end
                return;
            end
            casez (b)
                8'b0???????: begin
                    // Zero at a character start terminates the string silently.
                    if (b != 0) begin
                        push_char({23'd0, b}, 3'd1, 1'b0);
                    end
                    return;
                end
                8'b110?????: begin acc = {26'd0, b[4:0]}; char_len = 3'd2; end
                8'b1110????: begin acc = {27'd0, b[3:0]}; char_len = 3'd3; end
                8'b11110???: begin acc = {28'd0, b[2:0]}; char_len = 3'd4; end
                8'b111110??: begin acc = {29'd0, b[1:0]}; char_len = 3'd5; end
                8'b1111110?: begin acc = {30'd0, b[0]};   char_len = 3'd6; end
                default: begin
                    // Stray following byte, 0xFE or 0xFF: flag it and drop it.
                    push_char('0, 3'd1, 1'b1);
                    return;
                end
            endcase
            bytes_left = char_len - 1'b1;
        endfunction

        // Compare one accepted char beat against the oldest expectation.
        function void check_char(u8ks_pkg::t_result got);
            u8ks_pkg::t_result want;
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected char beat: keysym %h code_point %h count %0d",
                         $time, got.keysym, got.code_point, got.byte_count);
                errors++;
                return;
            end
            want = expected_chars.pop_front();
            if (got.keysym !== want.keysym) begin
                $display("%0t: keysym mismatch: expected %h, got %h",
                         $time, want.keysym, got.keysym);
                errors++;
            end
            if (got.code_point !== want.code_point) begin
                $display("%0t: code_point mismatch: expected %h, got %h",
                         $time, want.code_point, got.code_point);
                errors++;
            end
            if (got.byte_count !== want.byte_count) begin
                $display("%0t: byte_count mismatch: expected %0d, got %0d",
                         $time, want.byte_count, got.byte_count);
                errors++;
            end
            if (got.invalid !== want.invalid) begin
                $display("%0t: invalid mismatch: expected %0d, got %0d",
                         $time, want.invalid, got.invalid);
                errors++;
            end
        endfunction
    endclass

    localparam int RANDOM_BYTES = 750;

    logic i_clk;
    logic i_rst_n;

    u8ks_in_if  in_bus ();
    u8ks_out_if out_bus ();

    utf8_to_keysym_decoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    char_scoreboard sb = new();

    // When set, neither side idles: back-to-back beats in both directions.
    bit steady = 1'b0;
    int bytes_sent = 0;

    // Directed opener: terminator, plain ASCII and the top of the ASCII range,
    // the keysym range boundaries, the longest form at full value, every kind
    // of bad lead byte, a NUL byte inside a character and following bytes with bad top bits.
    logic [u8ks_pkg::BYTE_W-1:0] directed_bytes [25] = '{
        8'h00,                                  // terminator with nothing pending
        8'h41, 8'h7F,                           // plain ASCII, top of one-byte range
        8'hC4, 8'h80,                           // 0x100: lowest offset keysym
        8'hDF, 8'hBF,                           // 0x7FF: top of two-byte form
        8'hF4, 8'h8F, 8'hBF, 8'hBF,             // 0x10FFFF: highest offset keysym
        8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, // 0x7FFFFFFF: six-byte maximum
        8'h80, 8'hFE, 8'hFF,                    // bad leads
        8'hC3, 8'h00,                           // zero taken as a following byte
        8'hE1, 8'hC0, 8'hFF                     // following bytes with wrong top bits
    };

    initial begin
        i_clk = 1'b0;
    end
    always #10 i_clk = ~i_clk;

    // Hard stop well past the slowest legal run.
    initial begin
        #5_000_000;
        $display("utf8_to_keysym_decoder_tb: errors");
        $finish;
    end

    // Send one byte beat after a random gap; leave valid high on return so a
    // zero-gap next beat never lowers and raises it in the same step.
    task automatic send_byte(input logic [u8ks_pkg::BYTE_W-1:0] b);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid     <= 1'b1;
        in_bus.data_byte <= b;
        do @(posedge i_clk); while (!in_bus.ready);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    // Mostly well-formed characters of every length with random payload;
    // the rest is loose noise and terminators, and some following bytes are random.
    task automatic send_random_char();
        int pick;
        int len;
        int i;
        logic [u8ks_pkg::BYTE_W-1:0] lead;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            send_byte(8'($urandom));
            return;
        end
        if (pick < 12) begin
            send_byte(8'h00);
            return;
        end
        len = $urandom_range(1, 6);
        case (len)
            1:       lead = 8'($urandom_range(1, 127));
            2:       lead = {3'b110, 5'($urandom)};
            3:       lead = {4'b1110, 4'($urandom)};
            4:       lead = {5'b11110, 3'($urandom)};
            5:       lead = {6'b111110, 2'($urandom)};
            default: lead = {7'b1111110, 1'($urandom)};
        endcase
        send_byte(lead);
        for (i = 1; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_byte(8'($urandom));
            end else begin
                send_byte({2'b10, 6'($urandom)});
            end
        end
    endtask

    // Hold the input off until every owed character has come out.
    task automatic drain_chars();
        in_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_chars.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Output side: stall a random number of cycles before each char beat.
    initial begin
        int stall;
        u8ks_pkg::t_result got;
        out_bus.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 3);
            if (stall != 0) begin
                out_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!out_bus.valid);
            got.keysym     = out_bus.keysym;
            got.code_point = out_bus.code_point;
            got.byte_count = out_bus.byte_count;
            got.invalid    = out_bus.invalid;
            sb.check_char(got);
        end
    end

    // Input side and run control.
    initial begin
        int k;
        bit drained_mid;
        drained_mid      = 1'b0;
        i_rst_n          <= 1'b0;
        in_bus.valid     <= 1'b0;
        in_bus.data_byte <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < 25; k++) begin
            send_byte(directed_bytes[k]);
        end
        drain_chars();

        // Random traffic; flip between idling and back-to-back stretches now
        // and then, and drain once midway so a pause lands mid-run.
        while (bytes_sent < 25 + RANDOM_BYTES) begin
            if ($urandom_range(0, 40) == 0) begin
                steady = !steady;
            end
            if (!drained_mid && bytes_sent >= 25 + RANDOM_BYTES / 2) begin
                drain_chars();
                drained_mid = 1'b1;
            end
            send_random_char();
        end

        in_bus.valid <= 1'b0;
        while (sb.expected_chars.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (sb.errors == 0 && sb.expected_chars.size() == 0) begin
            $display("utf8_to_keysym_decoder_tb: clean");
        end else begin
            $display("utf8_to_keysym_decoder_tb: errors");
        end
        $finish;
    end

endmodule

// ===== utf8_to_keysym_decoder.f =====
rtl/u8ks_pkg.sv
rtl/u8ks_if.sv
rtl/u8ks_in_reg.sv
rtl/u8ks_step.sv
rtl/u8ks_out_reg.sv
rtl/utf8_to_keysym_decoder.sv
rtl/u8ks_checker.sv
bench/utf8_to_keysym_decoder_tb.sv
